/* rtl/assert_macros.svh */
// Assertion macros used by the port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`endif

/* rtl/tta_pkg.sv */
// Package: types, constants and helper functions of the lossless audio encoder.
`default_nettype none
package tta_pkg;
    localparam int TAPS = 8;
    localparam int MAX_BYTES = 64;
    localparam logic [9:0] BIT_LIMIT = 10'(8 * MAX_BYTES + 7);
    localparam logic [5:0] RICE_K_MAX = 6'd32;
    localparam logic [5:0] RICE_K_INIT = 6'd10;
    localparam logic [31:0] RICE_SUM_INIT = 32'd16384;
    localparam logic [31:0] SIGN32 = 32'h8000_0000;
    localparam logic [4:0] BPS_INIT = 5'd16;

    typedef struct packed {
        logic               opcode;
        logic signed [23:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       last;
        logic       overflow;
    } out_item_t;

    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef struct packed {
        logic load;
        logic pred;
        logic filt;
        logic upd;
        logic rice1;
        logic rice2;
        logic emit;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic tap_last;
        logic emit_done;
        logic flush_done;
    } status_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_PRED  = 8'b0000_0010,
        S_FILT  = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_RICE1 = 8'b0001_0000,
        S_RICE2 = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_FLUSH = 8'b1000_0000
    } state_t;

    // Power of two saturating at the sign bit.
    function automatic logic [31:0] pow2sat(input logic [6:0] n);
        logic [31:0] r;
        begin
            r = (n >= 7'd31) ? SIGN32 : (32'd1 << n[4:0]);
            return r;
        end
    endfunction

    // Step of the sign-sign adaptation: +-1 scaled.
    function automatic logic signed [3:0] sign_step(input logic [31:0] h,
                                                    input logic [3:0] mag);
        logic signed [3:0] r;
        begin
            r = h[31] ? -$signed(mag) : $signed(mag);
            return r;
        end
    endfunction
endpackage
`default_nettype wire

/* rtl/tta_ctrl.sv */
// Controller state machine of the lossless audio encoder.
`default_nettype none
module tta_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            in_opcode,
    output logic                 in_stall,
    output tta_pkg::cmd_t        cmd,
    input  wire tta_pkg::status_t st
);
    tta_pkg::state_t state_reg, state_next;

    // Advance the state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tta_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode commands and next state.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            tta_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = (in_opcode == tta_pkg::OP_FLUSH) ?
                                 tta_pkg::S_FLUSH : tta_pkg::S_PRED;
                end
            end
            tta_pkg::S_PRED:
            begin
                cmd.pred = 1'b1;
                state_next = tta_pkg::S_FILT;
            end
            tta_pkg::S_FILT:
            begin
                cmd.filt = 1'b1;
                if (st.tap_last)
                    state_next = tta_pkg::S_UPD;
            end
            tta_pkg::S_UPD:
            begin
                cmd.upd = 1'b1;
                state_next = tta_pkg::S_RICE1;
            end
            tta_pkg::S_RICE1:
            begin
                cmd.rice1 = 1'b1;
                state_next = tta_pkg::S_RICE2;
            end
            tta_pkg::S_RICE2:
            begin
                cmd.rice2 = 1'b1;
                state_next = tta_pkg::S_EMIT;
            end
            tta_pkg::S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (st.emit_done)
                    state_next = tta_pkg::S_IDLE;
            end
            tta_pkg::S_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (st.flush_done)
                    state_next = tta_pkg::S_IDLE;
            end
            default:
                state_next = tta_pkg::S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/tta_dp.sv */
// Datapath of the lossless audio encoder: predictor, filter, Rice coder, byte packer.
`default_nettype none
module tta_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [4:0]         cfg_data,
    input  wire tta_pkg::in_item_t  in_item,
    input  wire tta_pkg::cmd_t      cmd,
    output tta_pkg::status_t        st,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tta_pkg::out_item_t      out_item
);
    // Configuration and state registers.
    logic [4:0]         bps_reg;
    logic [31:0]        sample_reg;
    logic [31:0]        prev_reg;
    logic [31:0]        x1_reg;
    logic [31:0]        hist_reg [tta_pkg::TAPS];
    logic [31:0]        coef_reg [tta_pkg::TAPS];
    logic signed [3:0]  step_reg [tta_pkg::TAPS];
    logic [31:0]        lerr_reg;
    logic [31:0]        sum_reg;
    logic [31:0]        prod_reg;
    logic [3:0]         tap_reg;
    logic [5:0]         k1_reg, k2_reg;
    logic [31:0]        rs1_reg, rs2_reg;
    logic [31:0]        val_reg;
    logic               ge_reg;
    logic [5:0]         kc_reg;
    logic [7:0]         pb_reg;
    logic [2:0]         pc_reg;
    logic [9:0]         o_reg;
    logic [9:0]         total_reg;
    logic [32:0]        tail_reg;
    logic               clamp_reg;
    logic [6:0]         j_reg;
    logic               out_valid_reg;
    tta_pkg::out_item_t out_item_reg;

    // Shift amounts by sample width in bytes.
    logic [1:0] size_bytes;
    logic [4:0] pshift, fshift;
    always_comb
    begin
        if (bps_reg <= 5'd8)
            size_bytes = 2'd1;
        else if (bps_reg <= 5'd16)
            size_bytes = 2'd2;
        else
            size_bytes = 2'd3;
        pshift = (size_bytes == 2'd1) ? 5'd4 : 5'd5;
        fshift = (size_bytes == 2'd2) ? 5'd9 : 5'd10;
    end

    // Fixed first-order prediction.
    logic [31:0] pred_mul, pred, x1;
    assign pred_mul = (prev_reg << pshift) - prev_reg;
    assign pred = $signed(pred_mul) >>> pshift;
    assign x1 = sample_reg - pred;

    // Adapt one coefficient and form its product.
    logic [2:0]  tap_idx;
    logic [31:0] step32, coef_new, prod_next;
    assign tap_idx = tap_reg[2:0];
    assign step32 = 32'(step_reg[tap_idx]);
    always_comb
    begin
        if (lerr_reg[31])
            coef_new = coef_reg[tap_idx] - step32;
        else if (lerr_reg != '0)
            coef_new = coef_reg[tap_idx] + step32;
        else
            coef_new = coef_reg[tap_idx];
        prod_next = hist_reg[tap_idx] * coef_new;
    end

    // Residual and history difference chain.
    logic [31:0] err, h7n, h6n, h5n;
    assign err = x1_reg - 32'($signed(sum_reg) >>> fshift);
    assign h7n = x1_reg - hist_reg[7];
    assign h6n = h7n - hist_reg[6];
    assign h5n = h6n - hist_reg[5];

    // Zig-zag map and first Rice level.
    logic [31:0] zz, rs1_new, pw1;
    logic [5:0]  k1_new;
    always_comb
    begin
        if (lerr_reg != '0 && !lerr_reg[31])
            zz = (lerr_reg << 1) - 32'd1;
        else
            zz = 32'd0 - (lerr_reg << 1);
        rs1_new = rs1_reg + zz - (rs1_reg >> 4);
        if (k1_reg > 6'd0 && rs1_new < tta_pkg::pow2sat(7'(k1_reg) + 7'd4))
            k1_new = k1_reg - 6'd1;
        else if (rs1_new > tta_pkg::pow2sat(7'(k1_reg) + 7'd5) && k1_reg < tta_pkg::RICE_K_MAX)
            k1_new = k1_reg + 6'd1;
        else
            k1_new = k1_reg;
        pw1 = tta_pkg::pow2sat(7'(k1_reg));
    end

    // Second Rice level, unary length and clamp.
    logic [31:0] rs2_new, binval;
    logic [5:0]  k2_new, kk;
    logic [33:0] unary;
    logic [34:0] need;
    logic [9:0]  unary_c, o_new, total_new;
    logic        clamp;
    always_comb
    begin
        rs2_new = rs2_reg + val_reg - (rs2_reg >> 4);
        if (k2_reg > 6'd0 && rs2_new < tta_pkg::pow2sat(7'(k2_reg) + 7'd4))
            k2_new = k2_reg - 6'd1;
        else if (rs2_new > tta_pkg::pow2sat(7'(k2_reg) + 7'd5) && k2_reg < tta_pkg::RICE_K_MAX)
            k2_new = k2_reg + 6'd1;
        else
            k2_new = k2_reg;
        kk = ge_reg ? k2_reg : kc_reg;
        unary = ge_reg ? (34'd1 + 34'(val_reg >> kk)) : 34'd0;
        binval = val_reg & 32'((33'd1 << kk) - 33'd1);
        need = 35'(pc_reg) + 35'(unary) + 35'd1 + 35'(kk);
        clamp = need > 35'(tta_pkg::BIT_LIMIT);
        unary_c = clamp ? (tta_pkg::BIT_LIMIT - 10'(pc_reg) - 10'd1 - 10'(kk)) : unary[9:0];
        o_new = 10'(pc_reg) + unary_c;
        total_new = o_new + 10'd1 + 10'(kk);
    end

    // Byte of the code stream at the current byte index.
    logic [9:0]  sbit, dlt, gap;
    logic [7:0]  sbyte, pmask, rest_mask;
    logic [32:0] tshift;
    logic [6:0]  nbytes;
    always_comb
    begin
        sbit = {j_reg, 3'b000};
        dlt = sbit - o_reg;
        gap = o_reg - sbit;
        pmask = 8'((9'd1 << pc_reg) - 9'd1);
        sbyte = (sbit == '0) ? (pb_reg & pmask) : 8'd0;
        tshift = tail_reg >> dlt;
        if (sbit >= o_reg)
            sbyte = sbyte | tshift[7:0];
        else if (gap < 10'd8)
            sbyte = sbyte | (tail_reg[7:0] << gap[2:0]);
        rest_mask = 8'((9'd1 << total_reg[2:0]) - 9'd1);
        nbytes = total_reg[9:3];
    end

    // Output slot handshake.
    logic slot_free, emit_push, flush_push;
    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_push = cmd.emit && (j_reg != nbytes) && slot_free;
    assign flush_push = cmd.flush && (pc_reg != '0) && slot_free;
    assign st.tap_last = (tap_reg == 4'(tta_pkg::TAPS));
    assign st.emit_done = cmd.emit && (j_reg == nbytes);
    assign st.flush_done = cmd.flush && ((pc_reg == '0) || slot_free);

    logic clear_state;
    assign clear_state = st.flush_done;

    // Hold configuration across flushes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bps_reg <= tta_pkg::BPS_INIT;
        else if (cfg_we)
            bps_reg <= cfg_data;
    end

    // Update encoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            lerr_reg <= '0;
            k1_reg <= tta_pkg::RICE_K_INIT;
            k2_reg <= tta_pkg::RICE_K_INIT;
            rs1_reg <= tta_pkg::RICE_SUM_INIT;
            rs2_reg <= tta_pkg::RICE_SUM_INIT;
            pb_reg <= '0;
            pc_reg <= '0;
            tap_reg <= '0;
            j_reg <= '0;
            for (int i = 0; i < tta_pkg::TAPS; i++)
            begin
                hist_reg[i] <= '0;
                coef_reg[i] <= '0;
                step_reg[i] <= '0;
            end
        end
        else if (clear_state)
        begin
            prev_reg <= '0;
            lerr_reg <= '0;
            k1_reg <= tta_pkg::RICE_K_INIT;
            k2_reg <= tta_pkg::RICE_K_INIT;
            rs1_reg <= tta_pkg::RICE_SUM_INIT;
            rs2_reg <= tta_pkg::RICE_SUM_INIT;
            pb_reg <= '0;
            pc_reg <= '0;
            for (int i = 0; i < tta_pkg::TAPS; i++)
            begin
                hist_reg[i] <= '0;
                coef_reg[i] <= '0;
                step_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.pred)
            begin
                prev_reg <= sample_reg;
                tap_reg <= '0;
            end
            if (cmd.filt && !st.tap_last)
            begin
                coef_reg[tap_idx] <= coef_new;
                tap_reg <= tap_reg + 4'd1;
            end
            if (cmd.upd)
            begin
                lerr_reg <= err;
                for (int i = 0; i < 4; i++)
                begin
                    hist_reg[i] <= hist_reg[i + 1];
                    step_reg[i] <= step_reg[i + 1];
                end
                hist_reg[4] <= h5n;
                hist_reg[5] <= h6n;
                hist_reg[6] <= h7n;
                hist_reg[7] <= x1_reg;
                step_reg[4] <= tta_pkg::sign_step(hist_reg[4], 4'd1);
                step_reg[5] <= tta_pkg::sign_step(hist_reg[5], 4'd2);
                step_reg[6] <= tta_pkg::sign_step(hist_reg[6], 4'd2);
                step_reg[7] <= tta_pkg::sign_step(hist_reg[7], 4'd4);
            end
            if (cmd.rice1)
            begin
                rs1_reg <= rs1_new;
                k1_reg <= k1_new;
            end
            if (cmd.rice2)
            begin
                if (ge_reg)
                begin
                    rs2_reg <= rs2_new;
                    k2_reg <= k2_new;
                end
                j_reg <= '0;
            end
            if (emit_push)
                j_reg <= j_reg + 7'd1;
            if (st.emit_done)
            begin
                pc_reg <= total_reg[2:0];
                pb_reg <= sbyte & rest_mask;
            end
        end
    end

    // Hold working values of the current item.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sample_reg <= 32'(in_item.sample);
        if (cmd.pred)
        begin
            x1_reg <= x1;
            sum_reg <= 32'd1 << (fshift - 5'd1);
        end
        if (cmd.filt)
        begin
            prod_reg <= prod_next;
            if (tap_reg != '0)
                sum_reg <= sum_reg + prod_reg;
        end
        if (cmd.rice1)
        begin
            kc_reg <= k1_reg;
            ge_reg <= (zz >= pw1);
            val_reg <= (zz >= pw1) ? (zz - pw1) : zz;
        end
        if (cmd.rice2)
        begin
            o_reg <= o_new;
            total_reg <= total_new;
            tail_reg <= {binval, 1'b1};
            clamp_reg <= clamp;
        end
    end

    // Advance the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_push || flush_push)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_push)
        begin
            out_item_reg.code_byte <= sbyte;
            out_item_reg.last <= 1'b0;
            out_item_reg.overflow <= clamp_reg;
        end
        else if (flush_push)
        begin
            out_item_reg.code_byte <= pb_reg;
            out_item_reg.last <= 1'b1;
            out_item_reg.overflow <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;
endmodule
`default_nettype wire

/* rtl/tta_lossless_audio_encoder.sv */
// Top level of the lossless audio encoder.
// Usage:
//   Input channel in_valid/in_stall/in_item carries one item: an encode
//   opcode with a 24-bit signed sample, or a flush opcode. The block takes
//   one item at a time; in_stall is low only while it is idle.
//   An encode item passes load, predict, the filter steps for eight taps
//   through one shared multiplier, update and both Rice levels before its
//   first byte, then emits one byte per cycle while the receiver does not
//   stall, 0 to 64 bytes, and closes before it returns to idle.
//   A flush item emits the pending partial byte with last set (if any bits
//   are pending) and returns all coding state to its reset values.
//   Output channel out_valid/out_stall/out_item holds each byte in a
//   register; while the receiver stalls the byte stays and the packer waits.
//   cfg_we/cfg_data write bits_per_sample; write only while idle. Flush
//   keeps the register.
//   Reset (rst_n low, asynchronous) clears all coding state and sets
//   bits_per_sample to 16.
`default_nettype none
module tta_lossless_audio_encoder (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [4:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire tta_pkg::in_item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output tta_pkg::out_item_t      out_item
);
    tta_pkg::cmd_t    cmd;
    tta_pkg::status_t st;

    tta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_opcode (in_item.opcode),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .st        (st)
    );

    tta_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_item   (in_item),
        .cmd       (cmd),
        .st        (st),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );
endmodule
`default_nettype wire

/* rtl/tta_checker.sv */
// Port checker of the lossless audio encoder and its bind.
`default_nettype none
`include "assert_macros.svh"
module tta_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire tta_pkg::out_item_t out_item
);
    // A held byte stays until taken.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    // One item at a time: stall right after an accept.
    `ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)
    // A flush byte never carries overflow.
    `ASSERT_SAME(a_last_clean, clk, rst_n, out_valid && out_item.last, !out_item.overflow)
endmodule

bind tta_lossless_audio_encoder tta_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);
`default_nettype wire
